### src/trial_division_prime_test_assert.svh
// ----------------------------------------------------------------------------
// Trial-division prime test assertion macros
// Shared assertion shorthands for the checker of the prime test block.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TDPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial-division prime test package
// Widths and the interface between the sequencer and the serial divider.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int SQ_W        = VALUE_WIDTH + 1;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_resp_t;

endpackage

### src/tdpt_divider.sv
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring divider that takes one dividend bit per cycle and reports
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdpt_divider
    import tdpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    value_t           rem_reg;
    value_t           rem_next;
    value_t           quo_reg;
    value_t           quo_next;
    value_t           dsr_reg;
    value_t           dsr_next;
    logic [VALUE_WIDTH:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = VALUE_WIDTH'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign resp.done     = done_reg;
    assign resp.rem_zero = (rem_reg == '0);

endmodule

### src/trial_division_prime_test.sv
// The candidate is divided by one trial divisor after another; a divisor that leaves no remainder
// ends the test early. At most 254 trial divisors are used for 16 bits.
// Throughput: one candidate at a time; s_tready is high only while the block is idle.
// Reset: rst_n is asynchronous and active low; it returns the block to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
// Trial-division prime test
// Tests each candidate against divisors from two while the divisor squared
// does not exceed the candidate, and returns the candidate with a prime flag.
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] candidate
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [15:0] number, [16] is_prime, rest zero
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TEST   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    value_t            n_reg;
    value_t            n_next;
    value_t            d_reg;
    value_t            d_next;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   sq_next;
    logic              prime_reg;
    logic              prime_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [FIELD_W-1:0] out_num_reg;
    logic [FIELD_W-1:0] out_num_next;
    logic              out_prime_reg;
    logic              out_prime_next;
    logic [31:0]       cand_ext;
    logic [31:0]       n_ext;
    value_t            cand;
    div_req_t          div_req;
    div_resp_t         div_resp;

    assign cand_ext = 32'(s_tdata[FIELD_W-1:0]);
    assign cand     = cand_ext[VALUE_WIDTH-1:0];
    assign n_ext    = 32'(n_reg);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        out_prime_next = out_prime_reg;
        div_req.start    = 1'b0;
        div_req.dividend = n_reg;
        div_req.divisor  = d_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next     = cand;
                    d_next     = VALUE_WIDTH'(2);
                    sq_next    = SQ_W'(4);
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (n_reg < VALUE_WIDTH'(2))
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (sq_reg > {1'b0, n_reg})
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_resp.done)
                begin
                    if (div_resp.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(1);
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        state_next = ST_TEST;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = n_ext[FIELD_W-1:0];
                    out_prime_next = prime_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        out_num_reg   <= out_num_next;
        out_prime_reg <= out_prime_next;
    end

    tdpt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - FIELD_W - 1)'(0), out_prime_reg, out_num_reg};

endmodule

### src/tdpt_checker.sv
// ----------------------------------------------------------------------------
// Trial-division prime test checker
// Port-level assertions on the prime test block, attached by bind.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_assert.svh"

module tdpt_checker
    import tdpt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic in_beat;

    assign in_beat = s_tvalid && s_tready && (s_tdata == s_tdata);

    `TDPT_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, !s_tready, "ready held after input beat")
    `TDPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `TDPT_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:FIELD_W+1] == '0, "padding bits of result beat not zero")
    `TDPT_ASSERT_NOW(a_small_not_prime, clk, rst_n, m_tvalid && m_tdata[FIELD_W], m_tdata[FIELD_W-1:0] >= 16'd2, "number below two flagged prime")

endmodule

bind trial_division_prime_test tdpt_checker u_checker (.*);
